>>> rtl/assert_macros.svh
// ============================================================================
// Assertion macros
// Concurrent assertion helpers; empty when SYNTHESIS is defined.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_AT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// condition must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_AT(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

>>> rtl/fpid_pkg.sv
// ============================================================================
// fpid_pkg
// Shared constants, types and reset values of the five-axis PID controller.
// ============================================================================
`default_nettype none

package fpid_pkg;

    // axes with hardware behind them, and integral accumulator width
    localparam int AXIS_COUNT = 5;
    localparam int ACC_WIDTH  = 32;

    // axes with ports
    localparam int PORT_AXES  = 5;
    localparam int LANE_COUNT = (AXIS_COUNT < PORT_AXES) ? AXIS_COUNT : PORT_AXES;

    localparam int DATA_W   = 16;   // Q10.6 samples
    localparam int ERR_W    = DATA_W + 1;
    localparam int COEF_W   = 16;   // Q8.8 gains
    localparam int GAIN_W   = 3 * COEF_W;
    localparam int OUT_W    = 32;
    localparam int FRAC_SH  = 8;

    localparam int P_W      = ERR_W + COEF_W - FRAC_SH;   // 25
    localparam int DIFF_W   = P_W + 1;                    // 26
    localparam int MUL_B_W  = DIFF_W;
    localparam int PROD_W   = COEF_W + MUL_B_W;           // 42
    localparam int ITERM_W  = COEF_W + P_W - FRAC_SH;     // 33
    localparam int D_W      = COEF_W + DIFF_W - FRAC_SH;  // 34

    localparam int INT_SUM_W = ((ACC_WIDTH > ITERM_W) ? ACC_WIDTH : ITERM_W) + 1;
    localparam int OUT_SUM_W = ((ACC_WIDTH > D_W) ? ACC_WIDTH : D_W) + 2;

    localparam logic signed [INT_SUM_W-1:0] ACC_MAX =
        {{(INT_SUM_W - ACC_WIDTH + 1){1'b0}}, {(ACC_WIDTH - 1){1'b1}}};
    localparam logic signed [INT_SUM_W-1:0] ACC_MIN = ~ACC_MAX;
    localparam logic signed [OUT_SUM_W-1:0] OUT_MAX =
        {{(OUT_SUM_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
    localparam logic signed [OUT_SUM_W-1:0] OUT_MIN = ~OUT_MAX;

    // APB register map: one 64-bit word per axis at 8*index
    localparam int REG_IDX_W = $clog2(PORT_AXES);
    localparam int BYTE_SH   = 3;
    localparam int ADDR_W    = REG_IDX_W + BYTE_SH;
    localparam int PDATA_W   = 64;

    localparam logic [GAIN_W-1:0] GAIN_RESET [PORT_AXES] = '{
        48'd16492674416640,     // roll:     kp = 15.0
        48'd251788162760704,    // pitch:    kp = -27.0
        48'd7696581394688,      // yaw:      kp = 7.0
        48'd93458488360960,     // velocity: kp = 85.0
        48'd137438953472000     // depth:    kp = 125.0
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_P,
        ST_MUL_I,
        ST_MUL_D,
        ST_SUM,
        ST_WRITE
    } ctrl_state_t;

    // step strobes from the sequencer to every lane
    typedef struct packed {
        logic load;
        logic mul_p;
        logic mul_i;
        logic mul_d;
        logic sum;
    } lane_ctrl_t;

    typedef logic [PORT_AXES-1:0][GAIN_W-1:0] gain_bank_t;
    typedef logic [PORT_AXES-1:0][OUT_W-1:0]  result_bank_t;

endpackage

`default_nettype wire

>>> rtl/fpid_cfg.sv
// ============================================================================
// fpid_cfg
// APB gain register bank: one packed kp/ki/kd word per axis.
// ============================================================================
`default_nettype none

module fpid_cfg (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [fpid_pkg::ADDR_W-1:0] paddr,
    input  wire logic [fpid_pkg::PDATA_W-1:0] pwdata,
    output logic      [fpid_pkg::PDATA_W-1:0] prdata,
    output logic                             pready,
    output fpid_pkg::gain_bank_t             gains
);
    import fpid_pkg::*;

    logic [GAIN_W-1:0]    gain_reg [PORT_AXES];
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 idx_ok;
    logic                 wr_en;

    assign reg_idx = paddr[ADDR_W-1:BYTE_SH];
    assign idx_ok  = {1'b0, reg_idx} < (REG_IDX_W + 1)'(PORT_AXES);
    assign wr_en   = psel && penable && pwrite && idx_ok;
    assign pready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PORT_AXES; i++)
            begin
                gain_reg[i] <= GAIN_RESET[i];
            end
        end
        else if (wr_en)
        begin
            // bits above the packed gains drop
            gain_reg[reg_idx] <= pwdata[GAIN_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx_ok)
        begin
            prdata = PDATA_W'(gain_reg[reg_idx]);
        end
    end

    always_comb
    begin
        for (int i = 0; i < PORT_AXES; i++)
        begin
            gains[i] = gain_reg[i];
        end
    end

endmodule

`default_nettype wire

>>> rtl/fpid_lane.sv
// ============================================================================
// fpid_lane
// One axis of the PID: a single shared multiplier stepped through kp, ki, kd.
// ============================================================================
`default_nettype none

module fpid_lane (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  fpid_pkg::lane_ctrl_t                    ctrl,
    input  wire logic        [fpid_pkg::GAIN_W-1:0] gain_word,
    input  wire logic signed [fpid_pkg::DATA_W-1:0] measure,
    input  wire logic signed [fpid_pkg::DATA_W-1:0] target,
    output logic signed      [fpid_pkg::OUT_W-1:0]  result
);
    import fpid_pkg::*;

    logic signed [COEF_W-1:0]     kp;
    logic signed [COEF_W-1:0]     ki;
    logic signed [COEF_W-1:0]     kd;

    logic signed [ERR_W-1:0]      err_reg;
    logic signed [P_W-1:0]        p_reg;
    logic signed [P_W-1:0]        last_p_reg;
    logic signed [DIFF_W-1:0]     diff_reg;
    logic signed [ITERM_W-1:0]    iterm_reg;
    logic signed [D_W-1:0]        d_reg;
    logic signed [ACC_WIDTH-1:0]  integral_reg;
    logic signed [ACC_WIDTH-1:0]  integral_next;
    logic signed [OUT_W-1:0]      result_reg;
    logic signed [OUT_W-1:0]      result_next;

    logic signed [COEF_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]    mul_b;
    logic signed [PROD_W-1:0]     prod;
    logic signed [INT_SUM_W-1:0]  int_sum;
    logic signed [OUT_SUM_W-1:0]  out_sum;

    assign kp = $signed(gain_word[3*COEF_W-1:2*COEF_W]);
    assign ki = $signed(gain_word[2*COEF_W-1:COEF_W]);
    assign kd = $signed(gain_word[COEF_W-1:0]);

    // operand select for the shared multiplier
    always_comb
    begin
        priority if (ctrl.mul_i)
        begin
            mul_a = ki;
            mul_b = MUL_B_W'(p_reg);
        end
        else if (ctrl.mul_d)
        begin
            mul_a = kd;
            mul_b = diff_reg;
        end
        else
        begin
            mul_a = kp;
            mul_b = MUL_B_W'(err_reg);
        end
    end

    assign prod = mul_a * mul_b;

    always_comb
    begin
        int_sum = INT_SUM_W'(integral_reg) + INT_SUM_W'(iterm_reg);
        if (int_sum > ACC_MAX)
        begin
            integral_next = ACC_MAX[ACC_WIDTH-1:0];
        end
        else if (int_sum < ACC_MIN)
        begin
            integral_next = ACC_MIN[ACC_WIDTH-1:0];
        end
        else
        begin
            integral_next = int_sum[ACC_WIDTH-1:0];
        end
    end

    always_comb
    begin
        out_sum = OUT_SUM_W'(p_reg) + OUT_SUM_W'(integral_reg) + OUT_SUM_W'(d_reg);
        if (out_sum > OUT_MAX)
        begin
            result_next = OUT_MAX[OUT_W-1:0];
        end
        else if (out_sum < OUT_MIN)
        begin
            result_next = OUT_MIN[OUT_W-1:0];
        end
        else
        begin
            result_next = out_sum[OUT_W-1:0];
        end
    end

    // working registers: the shift right by eight is a bit select (floor)
    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            err_reg <= ERR_W'(measure) - ERR_W'(target);
        end
        if (ctrl.mul_p)
        begin
            p_reg <= prod[P_W+FRAC_SH-1:FRAC_SH];
        end
        if (ctrl.mul_i)
        begin
            iterm_reg <= prod[ITERM_W+FRAC_SH-1:FRAC_SH];
            diff_reg  <= DIFF_W'(last_p_reg) - DIFF_W'(p_reg);
        end
        if (ctrl.mul_d)
        begin
            d_reg <= prod[D_W+FRAC_SH-1:FRAC_SH];
        end
        if (ctrl.sum)
        begin
            result_reg <= result_next;
        end
    end

    // per-axis state carried from sample to sample
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            integral_reg <= '0;
            last_p_reg   <= '0;
        end
        else if (ctrl.mul_d)
        begin
            integral_reg <= integral_next;
            last_p_reg   <= p_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/fpid_merge.sv
// ============================================================================
// fpid_merge
// Output stage: gathers all lane corrections into one held result transfer.
// ============================================================================
`default_nettype none

module fpid_merge (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    load,
    input  fpid_pkg::result_bank_t       lane_results,
    input  wire logic                    out_ready,
    output logic                         out_valid,
    output fpid_pkg::result_bank_t       out_data,
    output logic                         free
);
    import fpid_pkg::*;

    logic         valid_reg;
    logic         valid_next;
    result_bank_t data_reg;

    assign free = !valid_reg || out_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= lane_results;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

>>> rtl/five_axis_pid_controller.sv
// ============================================================================
// five_axis_pid_controller
// Five-axis discrete PID: one lane per axis, a sequencer, and an output stage.
// ============================================================================
//  channel   handshake             payload
//  in        in_valid / in_ready   <axis>_measure, <axis>_target (Q10.6)
//  out       out_valid / out_ready <axis>_out (32-bit saturated)
//  cfg       APB psel/penable      paddr = 8*axis, kp/ki/kd in pwdata[47:0]
//
//  A sample steps the sequencer through accept, the kp, ki, kd multiply steps on
//  each lane's single multiplier, sum/saturate and write-out; the result loads
//  into the output register at the end of the write-out step.
//  All five axes run in parallel lanes; a new sample is accepted only after write-out.
//  A result waiting in the output register does not block the next sample;
//  only the write-out step holds while that register is still full.
//  Reset clears the integrals and previous P terms and restores default gains.
// ============================================================================
`default_nettype none
`include "assert_macros.svh"

module five_axis_pid_controller (
    input  wire logic                         clk,
    input  wire logic                         rst_n,

    input  wire logic                         in_valid,
    output logic                              in_ready,
    input  wire logic signed [15:0]           roll_measure,
    input  wire logic signed [15:0]           pitch_measure,
    input  wire logic signed [15:0]           yaw_measure,
    input  wire logic signed [15:0]           velocity_measure,
    input  wire logic signed [15:0]           depth_measure,
    input  wire logic signed [15:0]           roll_target,
    input  wire logic signed [15:0]           pitch_target,
    input  wire logic signed [15:0]           yaw_target,
    input  wire logic signed [15:0]           velocity_target,
    input  wire logic signed [15:0]           depth_target,

    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic signed [31:0]                roll_out,
    output logic signed [31:0]                pitch_out,
    output logic signed [31:0]                yaw_out,
    output logic signed [31:0]                velocity_out,
    output logic signed [31:0]                depth_out,

    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [fpid_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [fpid_pkg::PDATA_W-1:0] pwdata,
    output logic      [fpid_pkg::PDATA_W-1:0] prdata,
    output logic                              pready
);
    import fpid_pkg::*;

    ctrl_state_t   state_reg;
    ctrl_state_t   state_next;
    lane_ctrl_t    lane_ctrl;
    logic          merge_load;
    logic          merge_free;
    gain_bank_t    gains;
    result_bank_t  lane_results;
    result_bank_t  out_data;

    logic signed [DATA_W-1:0] measure_arr [PORT_AXES];
    logic signed [DATA_W-1:0] target_arr  [PORT_AXES];

    assign measure_arr[0] = roll_measure;
    assign measure_arr[1] = pitch_measure;
    assign measure_arr[2] = yaw_measure;
    assign measure_arr[3] = velocity_measure;
    assign measure_arr[4] = depth_measure;
    assign target_arr[0]  = roll_target;
    assign target_arr[1]  = pitch_target;
    assign target_arr[2]  = yaw_target;
    assign target_arr[3]  = velocity_target;
    assign target_arr[4]  = depth_target;

    fpid_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P: state_next = ST_MUL_I;
            ST_MUL_I: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_SUM;
            ST_SUM:   state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (merge_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready   = 1'b0;
        lane_ctrl  = '0;
        merge_load = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready       = 1'b1;
                lane_ctrl.load = in_valid;
            end
            ST_MUL_P: lane_ctrl.mul_p = 1'b1;
            ST_MUL_I: lane_ctrl.mul_i = 1'b1;
            ST_MUL_D: lane_ctrl.mul_d = 1'b1;
            ST_SUM:   lane_ctrl.sum   = 1'b1;
            ST_WRITE: merge_load      = merge_free;
            default:  in_ready        = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // one lane per computed axis; axes without a lane read as zero
    for (genvar a = 0; a < PORT_AXES; a++)
    begin : g_axis
        if (a < LANE_COUNT)
        begin : g_lane
            logic signed [OUT_W-1:0] lane_out;

            fpid_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (lane_ctrl),
                .gain_word (gains[a]),
                .measure   (measure_arr[a]),
                .target    (target_arr[a]),
                .result    (lane_out)
            );

            assign lane_results[a] = lane_out;
        end
        else
        begin : g_idle
            assign lane_results[a] = '0;
        end
    end

    fpid_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (merge_load),
        .lane_results (lane_results),
        .out_ready    (out_ready),
        .out_valid    (out_valid),
        .out_data     (out_data),
        .free         (merge_free)
    );

    assign roll_out     = $signed(out_data[0]);
    assign pitch_out    = $signed(out_data[1]);
    assign yaw_out      = $signed(out_data[2]);
    assign velocity_out = $signed(out_data[3]);
    assign depth_out    = $signed(out_data[4]);

    // an accepted sample starts the kp step on the next cycle
    `ASSERT_AT(a_accept_starts, clk, rst_n, (in_valid && in_ready) |=> (state_reg == ST_MUL_P))
    // never overwrite a result that is still waiting
    `ASSERT_NEVER(a_no_overwrite, clk, rst_n, merge_load && out_valid && !out_ready)
    // a new result only appears right after the write-out step
    `ASSERT_AT(a_rise_after_write, clk, rst_n, $rose(out_valid) |-> ($past(state_reg) == ST_WRITE))

endmodule

`default_nettype wire

>>> tb/sv/fpid_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// fpid_checker
// Watches the sample, correction and APB channels of the five-axis PID
// controller. Keeps its own gains, integrals and previous P terms, predicts
// the five corrections of every accepted sample and compares them, in order,
// with each correction transfer. Also checks APB read data against the gains.
// ============================================================================
module fpid_checker
    import fpid_pkg::*;
(
    input  logic                               clk,
    input  logic                               rst_n,

    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic [PORT_AXES-1:0][DATA_W-1:0]   measure_bus,
    input  logic [PORT_AXES-1:0][DATA_W-1:0]   target_bus,

    input  logic                               out_valid,
    input  logic                               out_ready,
    input  result_bank_t                       out_bus,

    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [ADDR_W-1:0]                  paddr,
    input  logic [PDATA_W-1:0]                 pwdata,
    input  logic [PDATA_W-1:0]                 prdata,
    input  logic                               pready,

    output int                                 fail_count,
    output int                                 open_count,
    output int                                 checked_count
);

    string        axis_name [PORT_AXES] = '{"roll", "pitch", "yaw", "velocity", "depth"};

    gain_bank_t   gain_copy;
    longint       integral_acc [PORT_AXES];
    longint       prev_prop    [PORT_AXES];
    result_bank_t correction_q [$];

    task automatic report_mismatch(input string msg);
        fail_count++;
        // keep the log short when the block is badly broken
        if (fail_count <= 40)
            $display("checker: %s", msg);
    endtask

    function automatic longint clamp_signed(input longint v, input int width);
        longint hi;
        longint lo;
        hi = (longint'(1) << (width - 1)) - 1;
        lo = -hi - 1;
        if (v > hi)
            return hi;
        if (v < lo)
            return lo;
        return v;
    endfunction

    // one control step over all axes; updates the integrals and previous P terms
    function automatic result_bank_t compute_corrections(
        input logic [PORT_AXES-1:0][DATA_W-1:0] meas,
        input logic [PORT_AXES-1:0][DATA_W-1:0] tgt
    );
        result_bank_t bank;
        longint       kp, ki, kd, err, p, d, total;
        int           a;
        bank = '0;
        for (a = 0; a < PORT_AXES; a++)
        begin
            if (a < AXIS_COUNT)
            begin
                kp  = longint'($signed(gain_copy[a][3*COEF_W-1:2*COEF_W]));
                ki  = longint'($signed(gain_copy[a][2*COEF_W-1:COEF_W]));
                kd  = longint'($signed(gain_copy[a][COEF_W-1:0]));
                err = longint'($signed(meas[a])) - longint'($signed(tgt[a]));
                // arithmetic shift floors, as the datapath does
                p   = (kp * err) >>> FRAC_SH;
                integral_acc[a] = clamp_signed(integral_acc[a] + ((ki * p) >>> FRAC_SH),
                                               ACC_WIDTH);
                d   = (kd * (prev_prop[a] - p)) >>> FRAC_SH;
                prev_prop[a] = p;
                total   = clamp_signed(p + integral_acc[a] + d, OUT_W);
                bank[a] = total[OUT_W-1:0];
            end
        end
        return bank;
    endfunction

    always @(posedge clk)
    begin
        result_bank_t want;
        int           reg_idx;
        int           a;
        if (!rst_n)
        begin
            for (a = 0; a < PORT_AXES; a++)
            begin
                gain_copy[a]    = GAIN_RESET[a];
                integral_acc[a] = 0;
                prev_prop[a]    = 0;
            end
            correction_q.delete();
            open_count <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                reg_idx = int'(paddr >> BYTE_SH);
                if (reg_idx < PORT_AXES)
                begin
                    if (pwrite)
                        gain_copy[reg_idx] = pwdata[GAIN_W-1:0];
                    else if (prdata[GAIN_W-1:0] != gain_copy[reg_idx])
                        report_mismatch($sformatf("read of %s gains: got %h, want %h",
                                        axis_name[reg_idx], prdata[GAIN_W-1:0],
                                        gain_copy[reg_idx]));
                end
            end

            // retire the oldest correction before predicting a new one
            if (out_valid && out_ready)
            begin
                if (correction_q.size() == 0)
                    report_mismatch("correction transfer with no sample pending");
                else
                begin
                    want = correction_q.pop_front();
                    checked_count++;
                    for (a = 0; a < PORT_AXES; a++)
                    begin
                        if (out_bus[a] != want[a])
                            report_mismatch($sformatf("correction %0d %s: got %0d, want %0d",
                                            checked_count, axis_name[a],
                                            $signed(out_bus[a]), $signed(want[a])));
                    end
                end
            end

            if (in_valid && in_ready)
                correction_q.push_back(compute_corrections(measure_bus, target_bus));

            open_count <= correction_q.size();
        end
    end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb
// Stimulus and verdict for the five-axis PID controller. Runs directed
// samples at the reset gains and at full-scale gains to hit integral and
// output saturation, then random samples under several gain settings with
// random idling on both channels; fpid_checker does all the comparing.
// ============================================================================
module tb;

    import fpid_pkg::*;

    typedef enum int {REG_ROLL, REG_PITCH, REG_YAW, REG_VELOCITY, REG_DEPTH} gain_reg_t;
    typedef enum int {STYLE_FULL, STYLE_SMALL, STYLE_EDGE} gain_style_t;

    localparam int RANDOM_PHASES = 5;
    localparam int PHASE_ITEMS   = 230;

    logic                             clk = 1'b0;
    logic                             rst_n;
    logic                             in_valid;
    logic                             in_ready;
    logic [PORT_AXES-1:0][DATA_W-1:0] measure_bus;
    logic [PORT_AXES-1:0][DATA_W-1:0] target_bus;
    logic                             out_valid;
    logic                             out_ready = 1'b0;
    logic signed [OUT_W-1:0]          roll_out, pitch_out, yaw_out, velocity_out, depth_out;
    result_bank_t                     out_bus;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [ADDR_W-1:0]                paddr;
    logic [PDATA_W-1:0]               pwdata;
    logic [PDATA_W-1:0]               prdata;
    logic                             pready;

    int                               fail_count;
    int                               open_count;
    int                               checked_count;
    int                               sample_count;
    int                               setting_count;
    bit                               calm;

    assign out_bus = {depth_out, velocity_out, yaw_out, pitch_out, roll_out};

    five_axis_pid_controller u_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .roll_measure     (measure_bus[0]),
        .pitch_measure    (measure_bus[1]),
        .yaw_measure      (measure_bus[2]),
        .velocity_measure (measure_bus[3]),
        .depth_measure    (measure_bus[4]),
        .roll_target      (target_bus[0]),
        .pitch_target     (target_bus[1]),
        .yaw_target       (target_bus[2]),
        .velocity_target  (target_bus[3]),
        .depth_target     (target_bus[4]),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .roll_out         (roll_out),
        .pitch_out        (pitch_out),
        .yaw_out          (yaw_out),
        .velocity_out     (velocity_out),
        .depth_out        (depth_out),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    fpid_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .measure_bus   (measure_bus),
        .target_bus    (target_bus),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_bus       (out_bus),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .fail_count    (fail_count),
        .open_count    (open_count),
        .checked_count (checked_count)
    );

    always #5 clk = ~clk;

    // receiver side: stall now and then, never inside a calm stretch
    always @(negedge clk)
    begin
        if (!rst_n)
            out_ready = 1'b0;
        else
            out_ready = calm || ($urandom_range(99) >= 7);
    end

    initial
    begin
        #5_000_000;
        $display("tb: done, errors");
        $finish;
    end

    function automatic logic [DATA_W-1:0] pick_sample();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return '0;
            default: return DATA_W'($urandom);
        endcase
    endfunction

    function automatic logic [COEF_W-1:0] pick_coef(input gain_style_t style);
        case (style)
            STYLE_SMALL: return COEF_W'($urandom_range(1023)) - COEF_W'(512);
            STYLE_EDGE:
            begin
                case ($urandom_range(4))
                    0:       return 16'h7FFF;
                    1:       return 16'h8000;
                    2:       return 16'h0000;
                    3:       return 16'h0100;
                    default: return 16'hFF00;
                endcase
            end
            default:     return COEF_W'($urandom);
        endcase
    endfunction

    task automatic apb_access(input bit is_write, input int idx, input logic [PDATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = is_write;
        paddr   = ADDR_W'(idx << BYTE_SH);
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (is_write && idx < PORT_AXES)
            setting_count++;
    endtask

    // leaves valid high after the transfer so back-to-back samples need no gap
    task automatic send_sample(input logic [PORT_AXES-1:0][DATA_W-1:0] meas,
                               input logic [PORT_AXES-1:0][DATA_W-1:0] tgt);
        @(negedge clk);
        while (!calm && $urandom_range(99) < 7)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid    = 1'b1;
        measure_bus = meas;
        target_bus  = tgt;
        do @(posedge clk); while (!in_ready);
        sample_count++;
    endtask

    task automatic send_uniform(input logic [DATA_W-1:0] m, input logic [DATA_W-1:0] t);
        send_sample({PORT_AXES{m}}, {PORT_AXES{t}});
    endtask

    task automatic drain_results();
        @(negedge clk);
        in_valid = 1'b0;
        wait (open_count == 0);
        @(negedge clk);
    endtask

    initial
    begin
        logic [PORT_AXES-1:0][DATA_W-1:0] meas;
        logic [PORT_AXES-1:0][DATA_W-1:0] tgt;
        logic [DATA_W-1:0]                m;
        gain_style_t                      style;
        int                               phase;
        int                               n;
        int                               a;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        measure_bus = '0;
        target_bus  = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        calm        = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // defaults: read them back, then walk the field extremes
        for (a = 0; a < PORT_AXES; a++)
            apb_access(1'b0, a, '0);
        send_uniform(16'h0000, 16'h0000);
        send_uniform(16'h7FFF, 16'h8000);
        send_uniform(16'h8000, 16'h7FFF);
        send_uniform(16'h7FFF, 16'h7FFF);
        send_uniform(16'h8000, 16'h8000);
        send_uniform(16'h7FFF, 16'h0000);
        send_uniform(16'h0000, 16'h8000);
        send_sample({16'h8000, 16'hAAAA, 16'h5555, 16'hFFFF, 16'h0001},
                    {16'h0001, 16'h5555, 16'hAAAA, 16'h0000, 16'hFFFF});

        // full-scale gains; upper pwdata bits and unmapped registers must be dropped
        drain_results();
        apb_access(1'b1, REG_ROLL,     {16'hA5A5, 16'h7FFF, 16'h7FFF, 16'h7FFF});
        apb_access(1'b1, REG_PITCH,    {16'hFFFF, 16'h8000, 16'h8000, 16'h8000});
        apb_access(1'b1, REG_YAW,      {16'h5A5A, 16'h8000, 16'h7FFF, 16'h0000});
        apb_access(1'b1, REG_VELOCITY, {16'h0000, 16'h7FFF, 16'h0000, 16'h8000});
        apb_access(1'b1, REG_DEPTH,    {16'h0000, 16'h0100, 16'h0100, 16'h0100});
        apb_access(1'b1, PORT_AXES, '1);
        apb_access(1'b1, (1 << REG_IDX_W) - 1, '1);
        for (a = 0; a < PORT_AXES; a++)
            apb_access(1'b0, a, '0);

        // hold the error at one extreme to saturate the integrals, then swing hard
        for (n = 0; n < 6; n++)
            send_uniform(16'h7FFF, 16'h8000);
        for (n = 0; n < 6; n++)
            send_uniform(16'h8000, 16'h7FFF);
        for (n = 0; n < 4; n++)
            send_uniform(n[0] ? 16'h7FFF : 16'h8000, n[0] ? 16'h8000 : 16'h7FFF);

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain_results();
            style = gain_style_t'(phase % 3);
            for (a = 0; a < PORT_AXES; a++)
                apb_access(1'b1, a, {16'($urandom), pick_coef(style), pick_coef(style),
                                     pick_coef(style)});
            apb_access(1'b1, $urandom_range((1 << REG_IDX_W) - 1, PORT_AXES),
                       {$urandom, $urandom});
            for (a = 0; a < PORT_AXES; a++)
                apb_access(1'b0, a, '0);

            calm = (phase == 2);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                // hold off once mid-phase until every correction is back
                if (phase == 3 && n == PHASE_ITEMS / 2)
                    drain_results();
                for (a = 0; a < PORT_AXES; a++)
                begin
                    m       = pick_sample();
                    meas[a] = m;
                    if ($urandom_range(3) == 0)
                        tgt[a] = m + DATA_W'($urandom_range(64)) - DATA_W'(32);
                    else
                        tgt[a] = pick_sample();
                end
                send_sample(meas, tgt);
            end
            calm = 1'b0;
        end

        drain_results();
        repeat (20) @(posedge clk);
        $display("tb: %0d samples sent, %0d corrections checked, %0d gain register writes",
                 sample_count, checked_count, setting_count);
        $display("tb: gains went from defaults through full-scale, random, small and edge sets");
        if (fail_count == 0 && open_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule
